### sv/lobm_pkg.sv
// Shared types, constants and codes of the limit order book matcher.
package lobm_pkg;

    localparam int NUM_LEVELS = 256;
    localparam int MAX_ORDERS = 64;
    localparam int LEVEL_W    = $clog2(NUM_LEVELS);
    localparam int SLOT_W     = $clog2(MAX_ORDERS);
    localparam int LV_ADDR_W  = LEVEL_W + 1;
    localparam int LV_DEPTH   = 2 * NUM_LEVELS;
    localparam int PRICE_W    = 16;
    localparam int QTY_W      = 24;
    localparam int ID_W       = 31;
    localparam int STAMP_W    = 32;
    localparam int K_W        = LEVEL_W + 2;
    localparam int REL_W      = PRICE_W + 2;

    localparam logic [1:0] CMD_LIMIT  = 2'd0;
    localparam logic [1:0] CMD_MARKET = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;

    localparam logic SIDE_BID = 1'b0;

    localparam logic REG_LOW_PRICE  = 1'b0;
    localparam logic REG_HIGH_PRICE = 1'b1;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_RESTED    = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_CANCELLED = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_REJECTED  = 3'd5
    } status_t;

    typedef logic [SLOT_W-1:0]    slot_idx_t;
    typedef logic [LV_ADDR_W-1:0] lv_addr_t;

    typedef struct packed {
        logic               ne;
        slot_idx_t          head;
        slot_idx_t          tail;
    } lv_word_t;

    typedef struct packed {
        logic [1:0]         command;
        logic               side;
        logic [PRICE_W-1:0] limit_price;
        logic [QTY_W-1:0]   quantity;
        logic [ID_W-1:0]    order_id;
        logic [STAMP_W-1:0] stamp;
    } order_t;

    typedef struct packed {
        logic               is_trade;
        logic [ID_W-1:0]    ask_id;
        logic [ID_W-1:0]    bid_id;
        logic [PRICE_W-1:0] fill_price;
        logic [QTY_W-1:0]   fill_qty;
        logic [STAMP_W-1:0] fill_stamp;
        logic [2:0]         status;
        logic [QTY_W-1:0]   remaining_qty;
        logic               last;
    } result_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LV_READ,
        S_LV_CHK,
        S_FILL,
        S_FINISH,
        S_REST_LINK,
        S_CAN_SCAN,
        S_UL_CHK,
        S_UL_WALK,
        S_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR,
        OP_LOAD,
        OP_LV_READ,
        OP_LV_TAKE,
        OP_STEP,
        OP_FILL,
        OP_SET_STATUS,
        OP_REST_SLOT,
        OP_REST_LINK,
        OP_CAN_NEXT,
        OP_CAN_HIT,
        OP_UL_TAKE,
        OP_UL_STEP,
        OP_UL_FIX,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t     op;
        status_t st;
        logic    idle;
    } ctl_t;

    typedef struct packed {
        logic       clr_done;
        logic       in_valid;
        logic [1:0] in_cmd;
        logic       lv_in_range;
        logic       rem_zero;
        logic       rd_lv_ne;
        logic       out_free;
        logic       fill_rem_done;
        logic       fill_lv_empty;
        logic       is_market;
        logic       rest_ok;
        logic       scan_hit;
        logic       scan_last;
        logic       ul_hit;
        logic       ul_at_tail;
    } sts_t;

endpackage

### sv/lobm_ifs.sv
// Channel interfaces: order input, result output and configuration write.
interface lobm_order_if import lobm_pkg::*; ();
    logic   valid;
    logic   ready;
    order_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface lobm_result_if import lobm_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface lobm_cfg_if import lobm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               index;
    logic [PRICE_W-1:0] wdata;
    modport source(output valid, output index, output wdata, input ready);
    modport sink(input valid, input index, input wdata, output ready);
endinterface

### sv/lobm_ctrl.sv
// Controller state machine sequencing matching, resting, cancel and result emission.
module lobm_ctrl import lobm_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output ctl_t ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (sts.in_valid)
                begin
                    priority if (sts.in_cmd == CMD_LIMIT || sts.in_cmd == CMD_MARKET)
                        state_next = S_LV_READ;
                    else if (sts.in_cmd == CMD_CANCEL)
                        state_next = S_CAN_SCAN;
                    else
                        state_next = S_EMIT;
                end
            end
            S_LV_READ:
            begin
                if (!sts.lv_in_range || sts.rem_zero)
                    state_next = S_FINISH;
                else
                    state_next = S_LV_CHK;
            end
            S_LV_CHK:
            begin
                if (sts.rd_lv_ne)
                    state_next = S_FILL;
                else
                    state_next = S_LV_READ;
            end
            S_FILL:
            begin
                if (sts.out_free)
                begin
                    priority if (sts.fill_rem_done)
                        state_next = S_FINISH;
                    else if (sts.fill_lv_empty)
                        state_next = S_LV_READ;
                    else
                        state_next = S_FILL;
                end
            end
            S_FINISH:
            begin
                if (sts.rem_zero || sts.is_market || !sts.rest_ok)
                    state_next = S_EMIT;
                else
                    state_next = S_REST_LINK;
            end
            S_REST_LINK:
            begin
                state_next = S_EMIT;
            end
            S_CAN_SCAN:
            begin
                priority if (sts.scan_hit)
                    state_next = S_UL_CHK;
                else if (sts.scan_last)
                    state_next = S_EMIT;
            end
            S_UL_CHK:
            begin
                if (sts.rd_lv_ne)
                    state_next = S_UL_WALK;
                else
                    state_next = S_EMIT;
            end
            S_UL_WALK:
            begin
                if (sts.ul_hit || sts.ul_at_tail)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        ctl.op   = OP_NONE;
        ctl.st   = ST_DONE;
        ctl.idle = (state_reg == S_IDLE);
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.op = OP_CLR;
            end
            S_IDLE:
            begin
                if (sts.in_valid)
                    ctl.op = OP_LOAD;
            end
            S_LV_READ:
            begin
                if (sts.lv_in_range && !sts.rem_zero)
                    ctl.op = OP_LV_READ;
            end
            S_LV_CHK:
            begin
                if (sts.rd_lv_ne)
                    ctl.op = OP_LV_TAKE;
                else
                    ctl.op = OP_STEP;
            end
            S_FILL:
            begin
                if (sts.out_free)
                    ctl.op = OP_FILL;
            end
            S_FINISH:
            begin
                priority if (sts.rem_zero)
                begin
                    ctl.op = OP_SET_STATUS;
                    ctl.st = ST_DONE;
                end
                else if (sts.is_market)
                begin
                    ctl.op = OP_SET_STATUS;
                    ctl.st = ST_DROPPED;
                end
                else if (!sts.rest_ok)
                begin
                    ctl.op = OP_SET_STATUS;
                    ctl.st = ST_REJECTED;
                end
                else
                begin
                    ctl.op = OP_REST_SLOT;
                end
            end
            S_REST_LINK:
            begin
                ctl.op = OP_REST_LINK;
            end
            S_CAN_SCAN:
            begin
                priority if (sts.scan_hit)
                    ctl.op = OP_CAN_HIT;
                else if (!sts.scan_last)
                    ctl.op = OP_CAN_NEXT;
            end
            S_UL_CHK:
            begin
                if (sts.rd_lv_ne)
                    ctl.op = OP_UL_TAKE;
            end
            S_UL_WALK:
            begin
                priority if (sts.ul_hit)
                    ctl.op = OP_UL_FIX;
                else if (!sts.ul_at_tail)
                    ctl.op = OP_UL_STEP;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                    ctl.op = OP_EMIT;
            end
            default:
            begin
                ctl.op = OP_NONE;
            end
        endcase
    end

endmodule

### sv/lobm_datapath.sv
// Datapath: band registers, order slot and price level memories, fill and result registers.
module lobm_datapath import lobm_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  ctl_t ctl,
    output sts_t sts,
    lobm_cfg_if.sink      cfg,
    lobm_order_if.sink    orders,
    lobm_result_if.source results
);

    localparam int TOP_W = PRICE_W + 1;

    // memories
    logic [ID_W-1:0]    ident_mem [MAX_ORDERS];
    logic [QTY_W-1:0]   qty_mem   [MAX_ORDERS];
    logic               side_mem  [MAX_ORDERS];
    logic [LEVEL_W-1:0] level_mem [MAX_ORDERS];
    slot_idx_t          next_mem  [MAX_ORDERS];
    lv_word_t           lv_mem    [LV_DEPTH];

    logic [ID_W-1:0]    rd_ident_reg;
    logic [QTY_W-1:0]   rd_qty_reg;
    logic               rd_side_reg;
    logic [LEVEL_W-1:0] rd_level_reg;
    slot_idx_t          rd_next_reg;
    lv_word_t           rd_lv_reg;

    logic [PRICE_W-1:0] low_reg, low_next;
    logic [PRICE_W-1:0] high_reg, high_next;
    lv_addr_t           clr_cnt_reg, clr_cnt_next;
    logic [MAX_ORDERS-1:0] valid_reg, valid_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic               prev_none_reg, prev_none_next;

    logic [1:0]         cmd_reg, cmd_next;
    logic               side_reg, side_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic [QTY_W-1:0]   rem_reg, rem_next;
    logic signed [K_W-1:0]   k_reg, k_next;
    logic signed [REL_W-1:0] bound_reg, bound_next;
    logic [LEVEL_W-1:0] rel_lvl_reg, rel_lvl_next;
    logic               band_ok_reg, band_ok_next;
    status_t            status_reg, status_next;
    slot_idx_t          ptr_reg, ptr_next;
    lv_addr_t           lv_addr_reg, lv_addr_next;
    slot_idx_t          lv_head_reg, lv_head_next;
    slot_idx_t          lv_tail_reg, lv_tail_next;
    slot_idx_t          prev_reg, prev_next;
    slot_idx_t          target_reg, target_next;
    result_t            pend_reg, pend_next;
    result_t            out_reg, out_next;

    // write ports
    logic               lv_we;
    lv_addr_t           lv_wa;
    lv_word_t           lv_wd;
    logic               qty_we;
    slot_idx_t          qty_wa;
    logic [QTY_W-1:0]   qty_wd;
    logic               new_we;
    logic               nx_we;
    slot_idx_t          nx_wa;
    slot_idx_t          nx_wd;

    // band
    logic [TOP_W-1:0]        low_top, top, low_ext;
    logic [LEVEL_W:0]        nlev;
    logic signed [REL_W-1:0] rel, nlev_s, nlev_m1, k_ext;
    logic                    in_is_limit;

    slot_idx_t          free_idx;
    logic               free_any;
    logic               out_free;
    logic [QTY_W-1:0]   fill_f;
    logic [QTY_W-1:0]   fill_left;
    result_t            fill_item;

    assign cfg.ready    = 1'b1;
    assign orders.ready = ctl.idle;
    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;
    assign out_free = !out_valid_reg || results.ready;

    always_comb
    begin
        low_ext     = {1'b0, low_reg};
        low_top     = low_ext + TOP_W'(NUM_LEVELS - 1);
        top         = ({1'b0, high_reg} < low_top) ? {1'b0, high_reg} : low_top;
        nlev        = (top >= low_ext) ? (LEVEL_W + 1)'(top - low_ext + TOP_W'(1)) : '0;
        nlev_s      = signed'(REL_W'(nlev));
        nlev_m1     = nlev_s - REL_W'(1);
        rel         = signed'({2'b00, orders.data.limit_price}) - signed'({2'b00, low_reg});
        in_is_limit = (orders.data.command == CMD_LIMIT);
        k_ext       = REL_W'(k_reg);
    end

    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = MAX_ORDERS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = SLOT_W'(i);
                free_any = 1'b1;
            end
        end
    end

    always_comb
    begin
        fill_f    = (rem_reg < rd_qty_reg) ? rem_reg : rd_qty_reg;
        fill_left = rd_qty_reg - fill_f;
        fill_item = '0;
        fill_item.is_trade   = 1'b1;
        fill_item.ask_id     = (side_reg == SIDE_BID) ? rd_ident_reg : id_reg;
        fill_item.bid_id     = (side_reg == SIDE_BID) ? id_reg : rd_ident_reg;
        fill_item.fill_price = low_reg + PRICE_W'(k_reg[LEVEL_W-1:0]);
        fill_item.fill_qty   = fill_f;
        fill_item.fill_stamp = stamp_reg;
    end

    always_comb
    begin
        sts.clr_done      = (clr_cnt_reg == lv_addr_t'(LV_DEPTH - 1));
        sts.in_valid      = orders.valid;
        sts.in_cmd        = orders.data.command;
        sts.lv_in_range   = (side_reg == SIDE_BID) ? (k_ext <= bound_reg) : (k_ext >= bound_reg);
        sts.rem_zero      = (rem_reg == '0);
        sts.rd_lv_ne      = rd_lv_reg.ne;
        sts.out_free      = out_free;
        sts.fill_rem_done = (rem_reg <= rd_qty_reg);
        sts.fill_lv_empty = (rd_qty_reg <= rem_reg) && (ptr_reg == lv_tail_reg);
        sts.is_market     = (cmd_reg == CMD_MARKET);
        sts.rest_ok       = band_ok_reg && free_any;
        sts.scan_hit      = valid_reg[ptr_reg] && (rd_ident_reg == id_reg);
        sts.scan_last     = (ptr_reg == slot_idx_t'(MAX_ORDERS - 1));
        sts.ul_hit        = (ptr_reg == target_reg);
        sts.ul_at_tail    = (ptr_reg == lv_tail_reg);
    end

    always_comb
    begin
        low_next        = low_reg;
        high_next       = high_reg;
        clr_cnt_next    = clr_cnt_reg;
        valid_next      = valid_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        prev_none_next  = prev_none_reg;
        cmd_next        = cmd_reg;
        side_next       = side_reg;
        id_next         = id_reg;
        stamp_next      = stamp_reg;
        rem_next        = rem_reg;
        k_next          = k_reg;
        bound_next      = bound_reg;
        rel_lvl_next    = rel_lvl_reg;
        band_ok_next    = band_ok_reg;
        status_next     = status_reg;
        ptr_next        = ptr_reg;
        lv_addr_next    = lv_addr_reg;
        lv_head_next    = lv_head_reg;
        lv_tail_next    = lv_tail_reg;
        prev_next       = prev_reg;
        target_next     = target_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        lv_we  = 1'b0;
        lv_wa  = lv_addr_reg;
        lv_wd  = '0;
        qty_we = 1'b0;
        qty_wa = ptr_reg;
        qty_wd = fill_left;
        new_we = 1'b0;
        nx_we  = 1'b0;
        nx_wa  = prev_reg;
        nx_wd  = rd_next_reg;

        if (cfg.valid)
        begin
            if (cfg.index == REG_LOW_PRICE)
                low_next = cfg.wdata;
            else
                high_next = cfg.wdata;
        end

        if (results.ready)
            out_valid_next = 1'b0;

        unique case (ctl.op)
            OP_NONE:
            begin
            end
            OP_CLR:
            begin
                lv_we        = 1'b1;
                lv_wa        = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + lv_addr_t'(1);
            end
            OP_LOAD:
            begin
                cmd_next        = orders.data.command;
                side_next       = orders.data.side;
                id_next         = orders.data.order_id;
                stamp_next      = orders.data.stamp;
                pend_valid_next = 1'b0;
                ptr_next        = '0;
                rel_lvl_next    = rel[LEVEL_W-1:0];
                band_ok_next    = (rel >= 0) && (rel < nlev_s);
                if (orders.data.side == SIDE_BID)
                begin
                    k_next     = '0;
                    bound_next = (in_is_limit && rel < nlev_m1) ? rel : nlev_m1;
                end
                else
                begin
                    k_next     = K_W'(nlev_m1);
                    bound_next = (in_is_limit && rel > 0) ? rel : '0;
                end
                priority if (orders.data.command == CMD_LIMIT
                             || orders.data.command == CMD_MARKET)
                begin
                    rem_next    = orders.data.quantity;
                    status_next = ST_DONE;
                end
                else if (orders.data.command == CMD_CANCEL)
                begin
                    rem_next    = '0;
                    status_next = ST_NOT_FOUND;
                end
                else
                begin
                    rem_next    = '0;
                    status_next = ST_REJECTED;
                end
            end
            OP_LV_READ:
            begin
                lv_addr_next = {~side_reg, k_reg[LEVEL_W-1:0]};
            end
            OP_LV_TAKE:
            begin
                lv_head_next = rd_lv_reg.head;
                lv_tail_next = rd_lv_reg.tail;
                ptr_next     = rd_lv_reg.head;
            end
            OP_STEP:
            begin
                k_next = (side_reg == SIDE_BID) ? k_reg + K_W'(1) : k_reg - K_W'(1);
            end
            OP_FILL:
            begin
                if (pend_valid_reg)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                end
                pend_next       = fill_item;
                pend_valid_next = 1'b1;
                rem_next        = rem_reg - fill_f;
                qty_we          = 1'b1;
                if (fill_left == '0)
                begin
                    valid_next[ptr_reg] = 1'b0;
                    lv_we = 1'b1;
                    if (ptr_reg == lv_tail_reg)
                    begin
                        lv_wd  = '{ne: 1'b0, head: lv_head_reg, tail: lv_tail_reg};
                        k_next = (side_reg == SIDE_BID) ? k_reg + K_W'(1) : k_reg - K_W'(1);
                    end
                    else
                    begin
                        lv_wd        = '{ne: 1'b1, head: rd_next_reg, tail: lv_tail_reg};
                        lv_head_next = rd_next_reg;
                        ptr_next     = rd_next_reg;
                    end
                end
            end
            OP_SET_STATUS:
            begin
                status_next = ctl.st;
            end
            OP_REST_SLOT:
            begin
                new_we               = 1'b1;
                valid_next[free_idx] = 1'b1;
                target_next          = free_idx;
                status_next          = ST_RESTED;
                lv_addr_next         = {side_reg, rel_lvl_reg};
            end
            OP_REST_LINK:
            begin
                lv_we = 1'b1;
                if (rd_lv_reg.ne)
                begin
                    nx_we = 1'b1;
                    nx_wa = rd_lv_reg.tail;
                    nx_wd = target_reg;
                    lv_wd = '{ne: 1'b1, head: rd_lv_reg.head, tail: target_reg};
                end
                else
                begin
                    lv_wd = '{ne: 1'b1, head: target_reg, tail: target_reg};
                end
            end
            OP_CAN_NEXT:
            begin
                ptr_next = ptr_reg + slot_idx_t'(1);
            end
            OP_CAN_HIT:
            begin
                valid_next[ptr_reg] = 1'b0;
                rem_next            = rd_qty_reg;
                status_next         = ST_CANCELLED;
                target_next         = ptr_reg;
                lv_addr_next        = {rd_side_reg, rd_level_reg};
            end
            OP_UL_TAKE:
            begin
                lv_head_next   = rd_lv_reg.head;
                lv_tail_next   = rd_lv_reg.tail;
                ptr_next       = rd_lv_reg.head;
                prev_none_next = 1'b1;
            end
            OP_UL_STEP:
            begin
                prev_next      = ptr_reg;
                prev_none_next = 1'b0;
                ptr_next       = rd_next_reg;
            end
            OP_UL_FIX:
            begin
                lv_we = 1'b1;
                if (prev_none_reg)
                begin
                    if (ptr_reg == lv_tail_reg)
                        lv_wd = '{ne: 1'b0, head: lv_head_reg, tail: lv_tail_reg};
                    else
                        lv_wd = '{ne: 1'b1, head: rd_next_reg, tail: lv_tail_reg};
                end
                else
                begin
                    nx_we = 1'b1;
                    if (ptr_reg == lv_tail_reg)
                        lv_wd = '{ne: 1'b1, head: lv_head_reg, tail: prev_reg};
                    else
                        lv_wd = '{ne: 1'b1, head: lv_head_reg, tail: lv_tail_reg};
                end
            end
            OP_EMIT:
            begin
                if (pend_valid_reg)
                    out_next = pend_reg;
                else
                    out_next = '0;
                out_next.status        = status_reg;
                out_next.remaining_qty = rem_reg;
                out_next.last          = 1'b1;
                out_valid_next         = 1'b1;
                pend_valid_next        = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg        <= '0;
            high_reg       <= PRICE_W'(255);
            clr_cnt_reg    <= '0;
            valid_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_none_reg  <= 1'b1;
        end
        else
        begin
            low_reg        <= low_next;
            high_reg       <= high_next;
            clr_cnt_reg    <= clr_cnt_next;
            valid_reg      <= valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            prev_none_reg  <= prev_none_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        side_reg    <= side_next;
        id_reg      <= id_next;
        stamp_reg   <= stamp_next;
        rem_reg     <= rem_next;
        k_reg       <= k_next;
        bound_reg   <= bound_next;
        rel_lvl_reg <= rel_lvl_next;
        band_ok_reg <= band_ok_next;
        status_reg  <= status_next;
        ptr_reg     <= ptr_next;
        lv_addr_reg <= lv_addr_next;
        lv_head_reg <= lv_head_next;
        lv_tail_reg <= lv_tail_next;
        prev_reg    <= prev_next;
        target_reg  <= target_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (lv_we)
            lv_mem[lv_wa] <= lv_wd;
        rd_lv_reg <= lv_mem[lv_addr_next];
    end

    always_ff @(posedge clk)
    begin
        if (new_we)
        begin
            ident_mem[free_idx] <= id_reg;
            side_mem[free_idx]  <= side_reg;
            level_mem[free_idx] <= rel_lvl_reg;
        end
        if (qty_we)
            qty_mem[qty_wa] <= qty_wd;
        else if (new_we)
            qty_mem[free_idx] <= rem_reg;
        if (nx_we)
            next_mem[nx_wa] <= nx_wd;
        rd_ident_reg <= ident_mem[ptr_next];
        rd_qty_reg   <= qty_mem[ptr_next];
        rd_side_reg  <= side_mem[ptr_next];
        rd_level_reg <= level_mem[ptr_next];
        rd_next_reg  <= next_mem[ptr_next];
    end

endmodule

### sv/limit_order_book_matcher.sv
// Top level of the limit order book matcher: controller plus datapath.
// Usage:
//   orders  - one transaction per order: limit, market or cancel by id.
//   results - one transaction per fill, the last one of an order carrying
//             status and remaining quantity with last set; an order without
//             fills yields exactly one status-only transaction.
//   cfg     - writes low_price (index 0) or high_price (index 1); always ready,
//             write only while the block is idle.
// Timing: an order is taken only when the previous one has been fully handled.
//   Matching reads and checks one price level after another while scanning empty
//   levels and makes one fill per cycle while the result register is free; resting
//   adds the slot and link steps before emission. A cancel scans the 64 order slots
//   one per cycle, then walks the level's queue one order per cycle.
// Reset: the book is emptied; a clearing pass over all 512 entries of the price
//   level memory follows, during which no order is taken.
// Stall: the result register holds while results.ready is low; a fill waits
//   until the result register is free, so no transaction is lost.
module limit_order_book_matcher import lobm_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    lobm_cfg_if.sink      cfg,
    lobm_order_if.sink    orders,
    lobm_result_if.source results
);

    ctl_t ctl;
    sts_t sts;

    lobm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .ctl   (ctl)
    );

    lobm_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .sts     (sts),
        .cfg     (cfg),
        .orders  (orders),
        .results (results)
    );

endmodule

### tb/sv/limit_order_book_matcher_tb.sv
// Testbench of the limit order book matcher: directed table, then random orders checked by a book predictor.
module limit_order_book_matcher_tb;
    import lobm_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count = 0;
    bit   hold_off = 1'b0;

    always #5 clk = ~clk;

    lobm_cfg_if    cfg();
    lobm_order_if  orders();
    lobm_result_if results();

    limit_order_book_matcher DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg.sink),
        .orders(orders.source),
        .results(results.sink)
    );

    // predictor copy of the book
    logic [15:0] band_low, band_high;
    bit          bk_valid[MAX_ORDERS];
    logic [30:0] bk_ident[MAX_ORDERS];
    logic [23:0] bk_qty[MAX_ORDERS];
    logic        bk_side[MAX_ORDERS];
    int          bk_level[MAX_ORDERS];
    int          bk_next[MAX_ORDERS];
    int          lv_head[LV_DEPTH];
    int          lv_tail[LV_DEPTH];
    bit          lv_ne[LV_DEPTH];

    result_t fills_due[$];
    bit      check_exact;
    result_t exact_val;
    logic [30:0] recent_ids[$];

    function automatic void book_reset();
        band_low = 16'd0;
        band_high = 16'd255;
        foreach (bk_valid[i]) bk_valid[i] = 1'b0;
        foreach (lv_ne[i]) lv_ne[i] = 1'b0;
    endfunction

    function automatic void push_fill(logic [30:0] ask, logic [30:0] bid,
                                      logic [15:0] px, logic [23:0] q, logic [31:0] st);
        result_t r;
        r = '0;
        r.is_trade = 1'b1;
        r.ask_id = ask;
        r.bid_id = bid;
        r.fill_price = px;
        r.fill_qty = q;
        r.fill_stamp = st;
        fills_due.push_back(r);
    endfunction

    function automatic void sweep(int lv, int lvl, logic sd, order_t o,
                                  ref logic [23:0] rem, ref int cnt);
        int s;
        logic [23:0] f;
        while (rem > 0 && lv_ne[lv] && cnt < MAX_ORDERS) begin
            s = lv_head[lv];
            f = (rem < bk_qty[s]) ? rem : bk_qty[s];
            rem -= f;
            bk_qty[s] -= f;
            if (sd == SIDE_BID)
                push_fill(bk_ident[s], o.order_id, band_low + lvl[15:0], f, o.stamp);
            else
                push_fill(o.order_id, bk_ident[s], band_low + lvl[15:0], f, o.stamp);
            cnt++;
            if (bk_qty[s] == 0) begin
                bk_valid[s] = 1'b0;
                if (s == lv_tail[lv])
                    lv_ne[lv] = 1'b0;
                else
                    lv_head[lv] = bk_next[s];
            end
        end
    endfunction

    function automatic void unlink(int lv, int s);
        int cur, prev, n;
        bit at_tail;
        if (!lv_ne[lv])
            return;
        cur = lv_head[lv];
        prev = -1;
        for (n = 0; n < MAX_ORDERS; n++) begin
            if (cur == s) begin
                at_tail = (cur == lv_tail[lv]);
                if (prev < 0) begin
                    if (at_tail)
                        lv_ne[lv] = 1'b0;
                    else
                        lv_head[lv] = bk_next[cur];
                end else begin
                    bk_next[prev] = bk_next[cur];
                    if (at_tail)
                        lv_tail[lv] = prev;
                end
                return;
            end
            if (cur == lv_tail[lv])
                return;
            prev = cur;
            cur = bk_next[cur];
        end
    endfunction

    function automatic void match_order(order_t o);
        int top, nlev, rel, hi, lo, k, cnt, s, fs, lv;
        logic [23:0] rem, report;
        status_t st;
        result_t r;
        rem = o.quantity;
        report = '0;
        cnt = 0;
        st = ST_DONE;
        top = int'(band_low) + NUM_LEVELS - 1;
        if (int'(band_high) < top)
            top = int'(band_high);
        nlev = top - int'(band_low) + 1;
        if (nlev < 0)
            nlev = 0;
        rel = int'(o.limit_price) - int'(band_low);
        if (o.command == CMD_LIMIT || o.command == CMD_MARKET) begin
            if (o.side == SIDE_BID) begin
                hi = nlev - 1;
                if (o.command == CMD_LIMIT && rel < hi)
                    hi = rel;
                for (k = 0; k <= hi && rem > 0; k++)
                    sweep(NUM_LEVELS + k, k, o.side, o, rem, cnt);
            end else begin
                lo = 0;
                if (o.command == CMD_LIMIT && rel > 0)
                    lo = rel;
                for (k = nlev - 1; k >= lo && rem > 0; k--)
                    sweep(k, k, o.side, o, rem, cnt);
            end
            report = rem;
            if (rem == 0)
                st = ST_DONE;
            else if (o.command == CMD_MARKET)
                st = ST_DROPPED;
            else begin
                fs = -1;
                for (s = 0; s < MAX_ORDERS; s++)
                    if (!bk_valid[s]) begin
                        fs = s;
                        break;
                    end
                if (rel < 0 || rel >= nlev || fs < 0)
                    st = ST_REJECTED;
                else begin
                    bk_valid[fs] = 1'b1;
                    bk_ident[fs] = o.order_id;
                    bk_qty[fs] = rem;
                    bk_side[fs] = o.side;
                    bk_level[fs] = rel;
                    bk_next[fs] = 0;
                    lv = (o.side ? NUM_LEVELS : 0) + rel;
                    if (lv_ne[lv]) begin
                        bk_next[lv_tail[lv]] = fs;
                        lv_tail[lv] = fs;
                    end else begin
                        lv_head[lv] = fs;
                        lv_tail[lv] = fs;
                        lv_ne[lv] = 1'b1;
                    end
                    st = ST_RESTED;
                    recent_ids.push_back(o.order_id);
                end
            end
        end else if (o.command == CMD_CANCEL) begin
            st = ST_NOT_FOUND;
            for (s = 0; s < MAX_ORDERS; s++)
                if (bk_valid[s] && bk_ident[s] == o.order_id) begin
                    unlink((bk_side[s] ? NUM_LEVELS : 0) + bk_level[s], s);
                    bk_valid[s] = 1'b0;
                    report = bk_qty[s];
                    st = ST_CANCELLED;
                    break;
                end
        end else
            st = ST_REJECTED;
        if (cnt == 0) begin
            r = '0;
            fills_due.push_back(r);
        end
        r = fills_due.pop_back();
        r.status = st;
        r.remaining_qty = report;
        r.last = 1'b1;
        fills_due.push_back(r);
    endfunction

    // result check
    always @(posedge clk) begin
        result_t exp_r;
        if (rst_n && results.valid && results.ready) begin
            if (fills_due.size() == 0) begin
                $display("%0t: unexpected result %p", $time, results.data);
                fail_count++;
            end else begin
                exp_r = fills_due.pop_front();
                if (results.data !== exp_r) begin
                    $display("%0t: mismatch expected %p actual %p", $time, exp_r, results.data);
                    fail_count++;
                end
                if (check_exact && results.data.last) begin
                    if (results.data !== exact_val) begin
                        $display("%0t: table mismatch expected %p actual %p",
                                 $time, exact_val, results.data);
                        fail_count++;
                    end
                end
            end
        end
    end

    // receiver stall pattern
    initial begin
        int n;
        results.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_off) begin
                results.ready <= 1'b0;
                for (n = 0; n < 300; n++)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            case ($urandom_range(0, 3))
                0: results.ready <= ($urandom_range(0, 7) != 0);
                1: results.ready <= $urandom_range(0, 1);
                default: results.ready <= 1'b1;
            endcase
        end
    end

    task automatic send_order(order_t o);
        orders.data <= o;
        orders.valid <= 1'b1;
        @(posedge clk);
        while (!orders.ready)
            @(posedge clk);
        match_order(o);
        if ($urandom_range(0, 3) == 0) begin
            orders.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        while (fills_due.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] v);
        orders.valid <= 1'b0;
        drain();
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.wdata <= v;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        if (idx == REG_LOW_PRICE)
            band_low = v;
        else
            band_high = v;
        @(posedge clk);
    endtask

    function automatic order_t mk(logic [1:0] c, logic sd, logic [15:0] px,
                                  logic [23:0] q, logic [30:0] id, logic [31:0] st);
        order_t o;
        o.command = c;
        o.side = sd;
        o.limit_price = px;
        o.quantity = q;
        o.order_id = id;
        o.stamp = st;
        return o;
    endfunction

    function automatic result_t mk_status(status_t st, logic [23:0] rem);
        result_t r;
        r = '0;
        r.status = st;
        r.remaining_qty = rem;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic order_t rand_order(int lo_px, int hi_px);
        order_t o;
        int sel;
        sel = $urandom_range(0, 19);
        o.side = $urandom_range(0, 1);
        o.limit_price = $urandom_range(lo_px, hi_px);
        o.quantity = ($urandom_range(0, 9) == 0) ? 24'($urandom) : $urandom_range(0, 40);
        o.order_id = ($urandom_range(0, 7) == 0) ? 31'($urandom) : $urandom_range(1, 40);
        o.stamp = $urandom;
        if (sel < 11)
            o.command = CMD_LIMIT;
        else if (sel < 15)
            o.command = CMD_MARKET;
        else if (sel < 19) begin
            o.command = CMD_CANCEL;
            if (recent_ids.size() != 0 && $urandom_range(0, 3) != 0)
                o.order_id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
        end else
            o.command = 2'd3;
        return o;
    endfunction

    typedef struct {
        order_t  o;
        bit      known;
        result_t r;
    } table_row_t;

    initial begin
        table_row_t rows[$];
        int i, p, lo_px, hi_px;
        book_reset();
        check_exact = 1'b0;
        orders.valid <= 1'b0;
        orders.data <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= REG_LOW_PRICE;
        cfg.wdata <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back('{mk(CMD_CANCEL, 0, 0, 5, 7, 1), 1, mk_status(ST_NOT_FOUND, 0)});
        rows.push_back('{mk(CMD_MARKET, 1, 0, 10, 1, 2), 1, mk_status(ST_DROPPED, 10)});
        rows.push_back('{mk(CMD_LIMIT, 0, 0, 0, 1, 3), 1, mk_status(ST_DONE, 0)});
        rows.push_back('{mk(2'd3, 1, 16'hFFFF, 24'hFFFFFF, 31'h7FFFFFFF, 32'hFFFFFFFF), 1,
                         mk_status(ST_REJECTED, 0)});
        rows.push_back('{mk(CMD_LIMIT, 0, 16'hFFFF, 9, 2, 4), 1, mk_status(ST_REJECTED, 9)});
        rows.push_back('{mk(CMD_LIMIT, 0, 10, 5, 3, 5), 1, mk_status(ST_RESTED, 5)});
        rows.push_back('{mk(CMD_LIMIT, 0, 10, 6, 4, 6), 1, mk_status(ST_RESTED, 6)});
        rows.push_back('{mk(CMD_LIMIT, 0, 255, 24'hFFFFFF, 31'h7FFFFFFF, 7), 1,
                         mk_status(ST_RESTED, 24'hFFFFFF)});
        rows.push_back('{mk(CMD_LIMIT, 0, 0, 3, 3, 8), 1, mk_status(ST_RESTED, 3)});
        rows.push_back('{mk(CMD_CANCEL, 0, 0, 0, 3, 9), 1, mk_status(ST_CANCELLED, 5)});
        rows.push_back('{mk(CMD_LIMIT, 1, 5, 20, 5, 32'hFFFFFFFF), 0, '0});
        rows.push_back('{mk(CMD_MARKET, 1, 0, 24'hFFFFFF, 6, 10), 0, '0});
        rows.push_back('{mk(CMD_LIMIT, 1, 200, 4, 8, 11), 0, '0});
        rows.push_back('{mk(CMD_LIMIT, 0, 220, 2, 9, 12), 0, '0});
        rows.push_back('{mk(CMD_MARKET, 0, 0, 9, 10, 13), 0, '0});
        rows.push_back('{mk(CMD_CANCEL, 1, 0, 0, 31'h7FFFFFFF, 14), 0, '0});
        foreach (rows[i]) begin
            orders.valid <= 1'b0;
            drain();
            check_exact = rows[i].known;
            exact_val = rows[i].r;
            send_order(rows[i].o);
            orders.valid <= 1'b0;
            drain();
        end
        check_exact = 1'b0;

        // fill the store: rejection when full
        for (i = 0; i < MAX_ORDERS + 2; i++)
            send_order(mk(CMD_LIMIT, 1, 16'(250), 1, 31'(100 + i), 32'(i)));
        send_order(mk(CMD_MARKET, 0, 0, 24'hFFFFFF, 31'h55, 32'h77));

        // band phases: narrow, extreme top, empty, narrow at zero, full width with a receiver hold-off
        for (p = 0; p < 5; p++) begin
            case (p)
                0: begin write_reg(REG_LOW_PRICE, 16'd100); write_reg(REG_HIGH_PRICE, 16'd109);
                   lo_px = 95; hi_px = 112; end
                1: begin write_reg(REG_LOW_PRICE, 16'hFF00); write_reg(REG_HIGH_PRICE, 16'hFFFF);
                   lo_px = 16'hFEF0; hi_px = 16'hFFFF; end
                2: begin write_reg(REG_LOW_PRICE, 16'd50); write_reg(REG_HIGH_PRICE, 16'd40);
                   lo_px = 30; hi_px = 60; end
                3: begin write_reg(REG_LOW_PRICE, 16'd0); write_reg(REG_HIGH_PRICE, 16'd3);
                   lo_px = 0; hi_px = 6; end
                default: begin write_reg(REG_LOW_PRICE, 16'd0);
                   write_reg(REG_HIGH_PRICE, 16'hFFFF); lo_px = 0; hi_px = 300; end
            endcase
            if (p == 4)
                hold_off = 1'b1;
            for (i = 0; i < ((p == 2) ? 20 : 60); i++) begin
                send_order(rand_order(lo_px, hi_px));
                if ($urandom_range(0, 12) == 0) begin
                    orders.valid <= 1'b0;
                    repeat ($urandom_range(5, 30)) @(posedge clk);
                end
            end
        end
        orders.valid <= 1'b0;
        drain();
        if (fills_due.size() == 0 && fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
